@@ rtl/llca_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llca_pkg
// Shared widths, codes and types of the life-like cellular automaton block.
// ----------------------------------------------------------------------------
package llca_pkg;

   // request fields
   localparam int ACTION_W = 2;
   localparam int ROW_W    = 5;
   localparam int COL_W    = 7;

   // register widths
   localparam int MASK_W = 9;
   localparam int ROWS_W = 6;
   localparam int COLS_W = 8;

   // register port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   // neighbor count, 0..8
   localparam int CNT_W = 4;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_STEP  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SURVIVE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIRTH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS    = 2'd3;

   // register reset values
   localparam logic [MASK_W-1:0] SURVIVE_RST = 9'd12;
   localparam logic [MASK_W-1:0] BIRTH_RST   = 9'd8;
   localparam logic [ROWS_W-1:0] ROWS_RST    = 6'd20;
   localparam logic [COLS_W-1:0] COLS_RST    = 8'd80;

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_FILL   = 6'b000100,
      ST_RUN    = 6'b001000,
      ST_LOOKUP = 6'b010000,
      ST_ACCESS = 6'b100000
   } state_type;

endpackage

@@ rtl/llca_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llca_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module llca_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/life_like_cellular_automaton_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_like_cellular_automaton_step
// Bounded grid of one-bit cells with cell write, cell read and generation step.
// ----------------------------------------------------------------------------
// The grid lives in one RAM, one row per entry, with a single read and a single
// write port. After reset the block clears the RAM one row a cycle and holds
// busy high until every row is cleared; register writes are taken during that
// time. A cell write, a cell read or an unused action keeps busy high for one
// cycle after start, and the next item is taken only once busy falls. A
// generation step streams the in-use rows through the RAM one row per cycle,
// writing row r back while row r+2 is read, and keeps busy high through
// ST_FILL, ST_RUN for each in-use row (rows_in_use capped at MAX_ROWS),
// ST_LOOKUP and ST_ACCESS; with an empty in-use area it takes the short path.
// Each item gives one result: rsp_valid is high for one cycle, the first cycle
// with busy low, and the receiver has no way to stall it.
// ----------------------------------------------------------------------------
module life_like_cellular_automaton_step #(
   parameter int MAX_ROWS = 32,
   parameter int MAX_COLS = 128
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             start,
   output logic                             busy,
   input  logic [llca_pkg::ACTION_W-1:0]    req_action,
   input  logic [llca_pkg::ROW_W-1:0]       req_row,
   input  logic [llca_pkg::COL_W-1:0]       req_col,
   input  logic                             req_write_value,

   output logic                             rsp_valid,
   output logic                             rsp_read_value,

   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [llca_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [llca_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import llca_pkg::*;

   localparam int AW  = $clog2(MAX_ROWS);
   localparam int RCW = $clog2(MAX_ROWS + 1);
   localparam int CW  = $clog2(MAX_COLS);

   state_type state_ff, state_in;
   logic [RCW-1:0] k_ff, k_in;

   logic [ACTION_W-1:0] act_ff, act_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic                wval_ff, wval_in;

   logic [MAX_COLS-1:0] above_ff, above_in;
   logic [MAX_COLS-1:0] cur_ff, cur_in;

   logic [MASK_W-1:0] survive_ff, birth_ff;
   logic [ROWS_W-1:0] rows_ff;
   logic [COLS_W-1:0] cols_ff;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_value_ff, rsp_value_in;

   // RAM ports
   logic                mem_wr_en, mem_rd_en;
   logic [AW-1:0]       mem_wr_addr, mem_rd_addr;
   logic [MAX_COLS-1:0] mem_wr_data, mem_rd_data;

   logic          accept;
   logic [RCW-1:0] nrows;
   logic [RCW:0]   k_p1, k_p2, nrows_x;
   logic          area_empty;
   logic          req_row_ok, row_ok, on_grid;
   logic [CW-1:0] col_idx;

   logic [MAX_COLS-1:0] cmask, below, a_m, m_m, b_m, next_row, cell_row;
   logic [MAX_COLS-1:0] a_l, a_r, m_l, m_r, b_l, b_r;
   logic [CNT_W-1:0]    nbr_cnt [MAX_COLS];

   llca_ram #(
      .WIDTH (MAX_COLS),
      .DEPTH (MAX_ROWS)
   ) u_grid (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;

   assign nrows      = (rows_ff > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(rows_ff);
   assign area_empty = (rows_ff == '0) || (cols_ff == '0);
   assign nrows_x    = {1'b0, nrows};
   assign k_p1       = {1'b0, k_ff} + 1'b1;
   assign k_p2       = {1'b0, k_ff} + 2'd2;

   assign req_row_ok = (int'(req_row) < MAX_ROWS);
   assign row_ok     = (int'(row_ff) < MAX_ROWS);
   assign on_grid    = row_ok && (int'(col_ff) < MAX_COLS);
   assign col_idx    = CW'(col_ff);

   // next generation of the row in cur_ff
   always_comb begin
      below = (k_p1 < nrows_x) ? mem_rd_data : '0;
      for (int c = 0; c < MAX_COLS; c++) begin
         cmask[c] = (c < int'(cols_ff));
      end
      a_m = above_ff & cmask;
      m_m = cur_ff & cmask;
      b_m = below & cmask;
      a_l = a_m << 1;
      a_r = a_m >> 1;
      m_l = m_m << 1;
      m_r = m_m >> 1;
      b_l = b_m << 1;
      b_r = b_m >> 1;
      for (int c = 0; c < MAX_COLS; c++) begin
         nbr_cnt[c] = CNT_W'(a_l[c]) + CNT_W'(a_m[c]) + CNT_W'(a_r[c])
                    + CNT_W'(m_l[c]) + CNT_W'(m_r[c])
                    + CNT_W'(b_l[c]) + CNT_W'(b_m[c]) + CNT_W'(b_r[c]);
         if (cmask[c]) begin
            next_row[c] = cur_ff[c] ? survive_ff[nbr_cnt[c]] : birth_ff[nbr_cnt[c]];
         end else begin
            next_row[c] = cur_ff[c];
         end
      end
   end

   // single-cell update of the row just read
   always_comb begin
      cell_row          = mem_rd_data;
      cell_row[col_idx] = wval_ff;
   end

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      act_in       = act_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      wval_in      = wval_ff;
      above_in     = above_ff;
      cur_in       = cur_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = '0;
      mem_wr_data  = '0;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = '0;

      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = AW'(k_ff);
            if (k_p1 == (RCW + 1)'(MAX_ROWS)) begin
               k_in     = '0;
               state_in = ST_IDLE;
            end else begin
               k_in = k_p1[RCW-1:0];
            end
         end
         ST_IDLE: begin
            if (accept) begin
               act_in  = req_action;
               row_in  = req_row;
               col_in  = req_col;
               wval_in = req_write_value;
               k_in    = '0;
               if (req_action == ACT_STEP && !area_empty) begin
                  mem_rd_en = 1'b1;
                  state_in  = ST_FILL;
               end else begin
                  mem_rd_en   = req_row_ok;
                  mem_rd_addr = AW'(req_row);
                  state_in    = ST_ACCESS;
               end
            end
         end
         ST_FILL: begin
            // row 0 arrives; the row above it is off the grid
            cur_in   = mem_rd_data;
            above_in = '0;
            if (nrows_x > (RCW + 1)'(1)) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = AW'(1);
            end
            state_in = ST_RUN;
         end
         ST_RUN: begin
            // write row k while row k+2 is fetched
            mem_wr_en   = 1'b1;
            mem_wr_addr = AW'(k_ff);
            mem_wr_data = next_row;
            above_in    = cur_ff;
            cur_in      = below;
            if (k_p2 < nrows_x) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = AW'(k_p2);
            end
            if (k_p1 == nrows_x) begin
               k_in     = '0;
               state_in = ST_LOOKUP;
            end else begin
               k_in = k_p1[RCW-1:0];
            end
         end
         ST_LOOKUP: begin
            mem_rd_en   = row_ok;
            mem_rd_addr = AW'(row_ff);
            state_in    = ST_ACCESS;
         end
         ST_ACCESS: begin
            rsp_valid_in = 1'b1;
            if (act_ff == ACT_WRITE && on_grid) begin
               mem_wr_en    = 1'b1;
               mem_wr_addr  = AW'(row_ff);
               mem_wr_data  = cell_row;
               rsp_value_in = wval_ff;
            end else begin
               rsp_value_in = on_grid ? mem_rd_data[col_idx] : 1'b0;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         survive_ff   <= SURVIVE_RST;
         birth_ff     <= BIRTH_RST;
         rows_ff      <= ROWS_RST;
         cols_ff      <= COLS_RST;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SURVIVE: survive_ff <= csr_wdata[MASK_W-1:0];
               CSR_BIRTH:   birth_ff   <= csr_wdata[MASK_W-1:0];
               CSR_ROWS:    rows_ff    <= csr_wdata[ROWS_W-1:0];
               CSR_COLS:    cols_ff    <= csr_wdata[COLS_W-1:0];
               default:     ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      wval_ff      <= wval_in;
      above_ff     <= above_in;
      cur_ff       <= cur_in;
      rsp_value_ff <= rsp_value_in;
   end

   // a cell access answers through ST_ACCESS and the registered rsp_valid
   a_cell_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_action == ACT_WRITE || req_action == ACT_READ)) |-> ##2 rsp_valid)
      else $error("cell access did not answer in time");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == ST_IDLE))
      else $error("result issued while busy");

   // the sweep never reads the row it is writing
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
      else $error("RAM read and write hit the same row");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mem_wr_en)
      else $error("RAM written while idle");

endmodule
